// ===== rtl/core/pxr_pkg.sv =====
// Package: constants, types and codes shared by the packet recovery files.
`default_nettype none
package pxr_pkg;
    localparam int NUM_ORIGINALS = 8;
    localparam int NUM_PARITY    = NUM_ORIGINALS / 2;
    localparam int NUM_SLOTS     = NUM_ORIGINALS + NUM_PARITY;
    localparam int BUFFER_BYTES  = 2048;
    localparam int OFF_W         = $clog2(BUFFER_BYTES);
    localparam int LEN_W         = OFF_W + 1;
    localparam int SLOT_W        = 4;
    localparam int ADDR_W        = SLOT_W + OFF_W;
    localparam int MEM_DEPTH     = NUM_SLOTS * BUFFER_BYTES;
    localparam int TOT_W         = 15;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [LEN_W-1:0]  t_len;

    localparam logic [2:0] V_HELD     = 3'd0;
    localparam logic [2:0] V_COMPLETE = 3'd1;
    localparam logic [2:0] V_UNCODED  = 3'd2;
    localparam logic [2:0] V_BAD      = 3'd3;
    localparam logic [2:0] V_BUSY     = 3'd4;

    typedef struct packed {
        logic        we;
        t_addr       waddr;
        logic [7:0]  wdata;
        t_addr       raddr_a;
        t_addr       raddr_b;
    } t_mem_req;
endpackage
`default_nettype wire

// ===== rtl/core/pxr_if.sv =====
// Interfaces: input item channel and result channel.
`default_nettype none
interface pxr_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [3:0]  label;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [31:0] seq_number;
    modport source (output valid, mode, label, payload_byte, last_byte, seq_number,
                    input ready);
    modport sink (input valid, mode, label, payload_byte, last_byte, seq_number,
                  output ready);
endinterface

interface pxr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [3:0]  recovered_count;
    logic [31:0] start_seq;
    logic [14:0] total_length;
    logic [7:0]  read_data;
    logic        read_valid;
    logic        read_last;
    logic        truncated;
    modport source (output valid, verdict, recovered_count, start_seq, total_length,
                    read_data, read_valid, read_last, truncated, input ready);
    modport sink (input valid, verdict, recovered_count, start_seq, total_length,
                  read_data, read_valid, read_last, truncated, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pairwise_xor_packet_recovery.sv =====
// Top level: pairwise XOR parity packet recovery with block reassembly.
//
// Input channel i_in carries one word per item: mode 0 is a payload byte of a
// packet (the first byte's label decides the packet's handling), mode 1 asks
// for the next reassembled byte. Output channel o_out carries one result per
// packet (on its last byte) and one per read item.
// A payload byte that does not end its packet leaves the block idle. A packet
// end goes through S_FIN and, when it rebuilds a missing original, through S_REB
// for the XOR pass over the store (one byte per cycle through the two read
// ports). A read goes through S_SK1, S_RDW and S_SK2 (straight to S_OUT when no
// block is complete), skipping empty originals.
// The result sits in an output register; the next item is accepted while it
// waits. If o_out stalls with a new result pending, the block holds.
// After reset, and after the read that delivers the final byte of a block,
// the payload store (24576 bytes) is zeroed one byte per cycle, during which
// no item is accepted.
`default_nettype none
module pairwise_xor_packet_recovery (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pxr_in_if.sink     i_in,
    pxr_out_if.source  o_out
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_FIN, S_REB, S_SK1, S_RDW, S_SK2, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        CL_STORE, CL_DUP, CL_IGNORE, CL_UNCODED, CL_BAD, CL_BUSY
    } t_pkt_class;

    localparam int CNT_W = 4;

    t_state               r_state;
    logic [pxr_pkg::ADDR_W-1:0] r_clr;
    logic                 r_clr_after;

    logic                 r_mid;
    logic [3:0]           r_plabel;
    t_pkt_class           r_pclass;
    logic                 r_acc;
    logic                 r_over;
    pxr_pkg::t_len        r_woff;

    pxr_pkg::t_len        r_len [pxr_pkg::NUM_SLOTS];
    logic [pxr_pkg::NUM_SLOTS-1:0] r_present;
    logic [CNT_W-1:0]     r_cnt;
    logic [31:0]          r_seq;
    logic [pxr_pkg::TOT_W-1:0] r_total;
    logic                 r_complete;
    logic [3:0]           r_dp;
    pxr_pkg::t_len        r_doff;

    pxr_pkg::t_slot       r_dst, r_par, r_src;
    pxr_pkg::t_len        r_rlen, r_ri;
    logic                 r_wpend;
    logic [pxr_pkg::OFF_W-1:0] r_wi;

    logic [2:0]           r_p_verdict;
    logic [7:0]           r_p_data;
    logic                 r_p_valid, r_p_last, r_p_trunc;

    logic                 r_ov;
    logic [2:0]           r_o_verdict;
    logic [3:0]           r_o_count;
    logic [31:0]          r_o_seq;
    logic [14:0]          r_o_total;
    logic [7:0]           r_o_data;
    logic                 r_o_valid, r_o_last, r_o_trunc;

    pxr_pkg::t_mem_req    mem_req;
    logic [7:0]           rd_a, rd_b;

    pxr_store u_store (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    // Byte path
    logic                 in_fire, first;
    logic [3:0]           e_label;
    t_pkt_class           c_class, e_class;
    logic                 e_acc, e_over, room;
    pxr_pkg::t_len        e_woff;
    pxr_pkg::t_slot       e_slot;
    logic [3:0]           k_o1;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign first      = !r_mid;

    always_comb begin
        k_o1 = 4'((i_in.label - 4'(pxr_pkg::NUM_ORIGINALS)) * 2 - 2);
        if (i_in.label == 4'd0) begin
            c_class = CL_UNCODED;
        end else if (i_in.label > 4'(pxr_pkg::NUM_SLOTS)) begin
            c_class = CL_BAD;
        end else if (r_complete) begin
            c_class = CL_BUSY;
        end else if (i_in.label <= 4'(pxr_pkg::NUM_ORIGINALS)) begin
            c_class = r_present[i_in.label - 4'd1] ? CL_DUP : CL_STORE;
        end else if (r_present[k_o1] && r_present[k_o1 + 4'd1]) begin
            c_class = CL_IGNORE;
        end else begin
            c_class = CL_STORE;
        end
    end

    assign e_label = first ? i_in.label : r_plabel;
    assign e_class = first ? c_class : r_pclass;
    assign e_acc   = first ? (c_class == CL_STORE) : r_acc;
    assign e_woff  = first ? '0 : r_woff;
    assign e_over  = first ? 1'b0 : r_over;
    assign room    = e_woff < pxr_pkg::LEN_W'(pxr_pkg::BUFFER_BYTES);
    assign e_slot  = e_label - 4'd1;

    // Packet end decisions
    pxr_pkg::t_slot       f_s, f_pair, f_parslot, f_o1, f_o2;
    pxr_pkg::t_slot       f_dst, f_src, f_par;
    logic                 f_orig, f_reb;
    pxr_pkg::t_len        f_rlen;
    logic [CNT_W-1:0]     f_cnt;
    logic [pxr_pkg::TOT_W-1:0] f_total;

    always_comb begin
        f_s       = r_plabel - 4'd1;
        f_orig    = r_plabel <= 4'(pxr_pkg::NUM_ORIGINALS);
        f_pair    = f_s ^ 4'd1;
        f_parslot = 4'(pxr_pkg::NUM_ORIGINALS) + (f_s >> 1);
        f_o1      = 4'((f_s - 4'(pxr_pkg::NUM_ORIGINALS)) * 2);
        f_o2      = f_o1 + 4'd1;
        f_reb     = 1'b0;
        f_dst     = f_pair;
        f_src     = f_s;
        f_par     = f_parslot;
        f_rlen    = r_len[f_parslot];
        if (f_orig) begin
            f_reb = (f_pair < 4'(pxr_pkg::NUM_ORIGINALS)) && r_present[f_parslot]
                    && !r_present[f_pair];
        end else begin
            f_par  = f_s;
            f_rlen = r_woff;
            if (r_present[f_o1] && !r_present[f_o2]) begin
                f_reb = 1'b1;
                f_dst = f_o2;
                f_src = f_o1;
            end else if (!r_present[f_o1] && r_present[f_o2]) begin
                f_reb = 1'b1;
                f_dst = f_o1;
                f_src = f_o2;
            end
        end
        f_cnt   = r_cnt + CNT_W'(f_orig) + CNT_W'(f_reb);
        f_total = r_total
                + (f_orig ? pxr_pkg::TOT_W'(r_woff) - pxr_pkg::TOT_W'(r_len[f_s]) : '0)
                + (f_reb ? pxr_pkg::TOT_W'(f_rlen) : '0);
    end

    // Drain skip check
    pxr_pkg::t_slot d_slot;
    logic           d_in_range, d_exhausted;
    assign d_slot      = r_dp - 4'd1;
    assign d_in_range  = r_dp <= 4'(pxr_pkg::NUM_ORIGINALS);
    assign d_exhausted = d_in_range && (r_doff >= r_len[d_slot]);

    // Store port selection
    always_comb begin
        mem_req         = '0;
        mem_req.raddr_a = {r_par, r_ri[pxr_pkg::OFF_W-1:0]};
        mem_req.raddr_b = {r_src, r_ri[pxr_pkg::OFF_W-1:0]};
        unique case (r_state)
            S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_clr;
            end
            S_IDLE: begin
                mem_req.we    = in_fire && !i_in.mode && room && e_acc;
                mem_req.waddr = {e_slot, e_woff[pxr_pkg::OFF_W-1:0]};
                mem_req.wdata = i_in.payload_byte;
            end
            S_REB: begin
                mem_req.we    = r_wpend;
                mem_req.waddr = {r_dst, r_wi};
                mem_req.wdata = rd_a ^ rd_b;
            end
            S_SK1: begin
                mem_req.raddr_a = {d_slot, r_doff[pxr_pkg::OFF_W-1:0]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_clr_after <= 1'b0;
            r_mid       <= 1'b0;
            r_acc       <= 1'b0;
            r_over      <= 1'b0;
            r_woff      <= '0;
            r_present   <= '0;
            r_cnt       <= '0;
            r_seq       <= '0;
            r_total     <= '0;
            r_complete  <= 1'b0;
            r_dp        <= 4'd1;
            r_doff      <= '0;
            r_wpend     <= 1'b0;
            r_ov        <= 1'b0;
            for (int i = 0; i < pxr_pkg::NUM_SLOTS; i++) begin
                r_len[i] <= '0;
            end
        end else begin
            // load a new word when the output register is free or being taken
            if (r_state == S_OUT && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == pxr_pkg::ADDR_W'(pxr_pkg::MEM_DEPTH - 1)) begin
                        r_clr   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_fire && !i_in.mode) begin
                        r_mid    <= !i_in.last_byte;
                        r_plabel <= e_label;
                        r_pclass <= e_class;
                        r_acc    <= e_acc;
                        if (first && i_in.label == 4'd1
                            && (c_class == CL_STORE || c_class == CL_DUP)) begin
                            r_seq <= i_in.seq_number;
                        end
                        if (room) begin
                            r_woff <= e_woff + 1'b1;
                            r_over <= e_over;
                        end else begin
                            r_woff <= e_woff;
                            r_over <= 1'b1;
                        end
                        if (i_in.last_byte) begin
                            r_state <= S_FIN;
                        end
                    end else if (in_fire) begin
                        r_p_data  <= '0;
                        r_p_valid <= 1'b0;
                        r_p_last  <= 1'b0;
                        r_p_trunc <= 1'b0;
                        r_clr_after <= 1'b0;
                        if (r_complete) begin
                            r_p_verdict <= pxr_pkg::V_COMPLETE;
                            r_state     <= S_SK1;
                        end else begin
                            r_p_verdict <= pxr_pkg::V_HELD;
                            r_state     <= S_OUT;
                        end
                    end
                end
                S_FIN: begin
                    r_p_data    <= '0;
                    r_p_valid   <= 1'b0;
                    r_p_last    <= 1'b0;
                    r_p_trunc   <= r_over;
                    r_clr_after <= 1'b0;
                    r_state     <= (r_pclass == CL_STORE && f_reb) ? S_REB : S_OUT;
                    case (r_pclass)
                        CL_UNCODED: r_p_verdict <= pxr_pkg::V_UNCODED;
                        CL_BAD:     r_p_verdict <= pxr_pkg::V_BAD;
                        CL_BUSY:    r_p_verdict <= pxr_pkg::V_BUSY;
                        CL_IGNORE:  r_p_verdict <= pxr_pkg::V_HELD;
                        CL_DUP: begin
                            r_p_verdict <= pxr_pkg::V_HELD;
                            r_len[f_s]  <= r_woff;
                            r_total     <= f_total;
                        end
                        default: begin
                            r_len[f_s]     <= r_woff;
                            r_present[f_s] <= 1'b1;
                            r_cnt          <= f_cnt;
                            r_total        <= f_total;
                            if (f_reb) begin
                                r_len[f_dst]     <= f_rlen;
                                r_present[f_dst] <= 1'b1;
                                r_dst   <= f_dst;
                                r_par   <= f_par;
                                r_src   <= f_src;
                                r_rlen  <= f_rlen;
                                r_ri    <= '0;
                                r_wpend <= 1'b0;
                            end
                            if (f_cnt >= CNT_W'(pxr_pkg::NUM_ORIGINALS)) begin
                                r_complete  <= 1'b1;
                                r_dp        <= 4'd1;
                                r_doff      <= '0;
                                r_p_verdict <= pxr_pkg::V_COMPLETE;
                            end else begin
                                r_p_verdict <= pxr_pkg::V_HELD;
                            end
                        end
                    endcase
                end
                S_REB: begin
                    if (r_ri < r_rlen) begin
                        r_ri    <= r_ri + 1'b1;
                        r_wi    <= r_ri[pxr_pkg::OFF_W-1:0];
                        r_wpend <= 1'b1;
                    end else begin
                        r_wpend <= 1'b0;
                        if (!r_wpend) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SK1: begin
                    if (d_exhausted) begin
                        r_dp   <= r_dp + 4'd1;
                        r_doff <= '0;
                    end else if (!d_in_range) begin
                        r_clr_after <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_state <= S_RDW;
                    end
                end
                S_RDW: begin
                    r_p_data  <= rd_a;
                    r_p_valid <= 1'b1;
                    r_doff    <= r_doff + 1'b1;
                    r_state   <= S_SK2;
                end
                S_SK2: begin
                    if (d_exhausted) begin
                        r_dp   <= r_dp + 4'd1;
                        r_doff <= '0;
                    end else begin
                        r_p_last    <= !d_in_range;
                        r_clr_after <= !d_in_range;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_o_verdict <= r_p_verdict;
                        r_o_count   <= r_cnt;
                        r_o_seq     <= r_seq;
                        r_o_total   <= r_complete ? r_total : '0;
                        r_o_data    <= r_p_data;
                        r_o_valid   <= r_p_valid;
                        r_o_last    <= r_p_last;
                        r_o_trunc   <= r_p_trunc;
                        if (r_clr_after) begin
                            // drop the finished block and zero the store
                            r_present  <= '0;
                            r_cnt      <= '0;
                            r_seq      <= '0;
                            r_total    <= '0;
                            r_complete <= 1'b0;
                            r_dp       <= 4'd1;
                            r_doff     <= '0;
                            for (int i = 0; i < pxr_pkg::NUM_SLOTS; i++) begin
                                r_len[i] <= '0;
                            end
                            r_clr   <= '0;
                            r_state <= S_CLEAR;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.verdict         = r_o_verdict;
    assign o_out.recovered_count = r_o_count;
    assign o_out.start_seq       = r_o_seq;
    assign o_out.total_length    = r_o_total;
    assign o_out.read_data       = r_o_data;
    assign o_out.read_valid      = r_o_valid;
    assign o_out.read_last       = r_o_last;
    assign o_out.truncated       = r_o_trunc;
endmodule
`default_nettype wire

// ===== rtl/core/pxr_store.sv =====
// Payload store: one write port, two registered read ports.
`default_nettype none
module pxr_store (
    input  wire logic              i_clk,
    input  wire pxr_pkg::t_mem_req i_req,
    output logic [7:0]             o_rd_a,
    output logic [7:0]             o_rd_b
);
    logic [7:0] mem [pxr_pkg::MEM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        o_rd_a <= mem[i_req.raddr_a];
        o_rd_b <= mem[i_req.raddr_b];
    end
endmodule
`default_nettype wire

// ===== tb/pxr_checker.sv =====
// Checker: watches both channels, predicts each result of the recovery block and compares it.
module pxr_checker
    import pxr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pxr_in_if         i_in,
    pxr_out_if        i_out,
    output int        o_errors,
    output int        o_pending,
    output int        o_drain_left,
    output bit        o_complete
);
    typedef enum int {PK_STORE, PK_DUP, PK_IGNORE, PK_UNCODED, PK_BAD, PK_BUSY} t_pkt_kind;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [3:0]  recovered_count;
        logic [31:0] start_seq;
        logic [14:0] total_length;
        logic [7:0]  read_data;
        logic        read_valid;
        logic        read_last;
        logic        truncated;
    } t_result;

    logic [7:0] store_mem [MEM_DEPTH];
    int         slot_len [NUM_SLOTS+1];
    bit         slot_here [NUM_SLOTS+1];
    int         orig_count;
    logic [31:0] seq_held;
    int         wr_off;
    bit         wr_enable;
    int         rd_slot;
    int         rd_off;
    bit         complete;
    bit         in_packet;
    int         cur_label;
    t_pkt_kind  cur_kind;
    bit         cur_over;
    t_result    result_q [$];

    function automatic int base_of(int slot);
        return (slot - 1) * BUFFER_BYTES;
    endfunction

    function automatic void wipe_block();
        foreach (store_mem[i]) store_mem[i] = '0;
        for (int i = 0; i <= NUM_SLOTS; i++) begin
            slot_len[i] = 0;
            slot_here[i] = 0;
        end
        orig_count = 0;
        seq_held = '0;
        complete = 0;
        rd_slot = 1;
        rd_off = 0;
    endfunction

    function automatic t_pkt_kind kind_of(int lbl);
        int k;
        if (lbl == 0) return PK_UNCODED;
        if (lbl > NUM_SLOTS) return PK_BAD;
        if (complete) return PK_BUSY;
        if (lbl <= NUM_ORIGINALS) return slot_here[lbl] ? PK_DUP : PK_STORE;
        k = lbl - NUM_ORIGINALS;
        if (slot_here[2*k-1] && slot_here[2*k]) return PK_IGNORE;
        return PK_STORE;
    endfunction

    function automatic void xor_rebuild(int dst, int par, int src);
        int n;
        n = slot_len[par];
        if (n > BUFFER_BYTES) n = BUFFER_BYTES;
        for (int i = 0; i < n; i++)
            store_mem[base_of(dst)+i] = store_mem[base_of(par)+i] ^ store_mem[base_of(src)+i];
        slot_len[dst] = n;
        slot_here[dst] = 1;
        orig_count++;
    endfunction

    function automatic int sum_lengths();
        int s;
        s = 0;
        for (int i = 1; i <= NUM_ORIGINALS; i++) s += slot_len[i];
        return s;
    endfunction

    function automatic logic [2:0] close_packet();
        int lbl, mate, par, o1, o2;
        lbl = cur_label;
        case (cur_kind)
            PK_UNCODED: return V_UNCODED;
            PK_BAD:     return V_BAD;
            PK_BUSY:    return V_BUSY;
            PK_IGNORE:  return V_HELD;
            PK_DUP: begin
                slot_len[lbl] = wr_off;
                return V_HELD;
            end
            default: ;
        endcase
        slot_len[lbl] = wr_off;
        slot_here[lbl] = 1;
        if (lbl <= NUM_ORIGINALS) begin
            mate = (lbl % 2) ? lbl + 1 : lbl - 1;
            par = (lbl + 1) / 2 + NUM_ORIGINALS;
            orig_count++;
            if (mate <= NUM_ORIGINALS && slot_here[par] && !slot_here[mate])
                xor_rebuild(mate, par, lbl);
        end else begin
            o2 = (lbl - NUM_ORIGINALS) * 2;
            o1 = o2 - 1;
            if (slot_here[o1] && !slot_here[o2]) xor_rebuild(o2, lbl, o1);
            else if (!slot_here[o1] && slot_here[o2]) xor_rebuild(o1, lbl, o2);
        end
        if (orig_count >= NUM_ORIGINALS) begin
            complete = 1;
            rd_slot = 1;
            rd_off = 0;
            return V_COMPLETE;
        end
        return V_HELD;
    endfunction

    function automatic void skip_empty();
        while (rd_slot <= NUM_ORIGINALS && rd_off >= slot_len[rd_slot]) begin
            rd_slot++;
            rd_off = 0;
        end
    endfunction

    // Returns 1 when the word produces a result.
    function automatic bit recover_step(logic mode, logic [3:0] lbl, logic [7:0] data,
                                        logic last, logic [31:0] seq, output t_result r);
        bit wipe;
        wipe = 0;
        r = '0;
        if (!mode) begin
            if (!in_packet) begin
                in_packet = 1;
                cur_label = lbl;
                cur_kind = kind_of(lbl);
                wr_enable = (cur_kind == PK_STORE);
                cur_over = 0;
                wr_off = 0;
                if (lbl == 1 && (cur_kind == PK_STORE || cur_kind == PK_DUP)) seq_held = seq;
            end
            if (wr_off < BUFFER_BYTES) begin
                if (wr_enable) store_mem[base_of(cur_label)+wr_off] = data;
                wr_off++;
            end else begin
                cur_over = 1;
            end
            if (!last) return 0;
            r.verdict = close_packet();
            r.truncated = cur_over;
            in_packet = 0;
            wr_enable = 0;
            wr_off = 0;
            r.recovered_count = orig_count;
            r.start_seq = seq_held;
            r.total_length = complete ? sum_lengths() : 0;
        end else begin
            r.recovered_count = orig_count;
            r.start_seq = seq_held;
            r.total_length = complete ? sum_lengths() : 0;
            if (!complete) begin
                r.verdict = V_HELD;
            end else begin
                r.verdict = V_COMPLETE;
                skip_empty();
                if (rd_slot > NUM_ORIGINALS) begin
                    wipe = 1;
                end else begin
                    r.read_data = store_mem[base_of(rd_slot)+rd_off];
                    r.read_valid = 1;
                    rd_off++;
                    skip_empty();
                    if (rd_slot > NUM_ORIGINALS) begin
                        r.read_last = 1;
                        wipe = 1;
                    end
                end
            end
        end
        if (wipe) wipe_block();
        return 1;
    endfunction

    function automatic int bytes_to_drain();
        int s;
        s = 0;
        if (!complete) return 0;
        for (int i = rd_slot; i <= NUM_ORIGINALS; i++)
            s += (i == rd_slot) ? slot_len[i] - rd_off : slot_len[i];
        return s;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            wipe_block();
            wr_off = 0;
            wr_enable = 0;
            in_packet = 0;
            cur_label = 0;
            cur_kind = PK_STORE;
            cur_over = 0;
            result_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = {i_out.verdict, i_out.recovered_count, i_out.start_seq,
                       i_out.total_length, i_out.read_data, i_out.read_valid,
                       i_out.read_last, i_out.truncated};
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected word", got.verdict, 0);
                end else begin
                    want = result_q.pop_front();
                    if (got.verdict !== want.verdict)
                        report_mismatch("verdict", got.verdict, want.verdict);
                    if (got.recovered_count !== want.recovered_count)
                        report_mismatch("recovered_count", got.recovered_count,
                                        want.recovered_count);
                    if (got.start_seq !== want.start_seq)
                        report_mismatch("start_seq", got.start_seq, want.start_seq);
                    if (got.total_length !== want.total_length)
                        report_mismatch("total_length", got.total_length, want.total_length);
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", got.read_data, want.read_data);
                    if (got.read_valid !== want.read_valid)
                        report_mismatch("read_valid", got.read_valid, want.read_valid);
                    if (got.read_last !== want.read_last)
                        report_mismatch("read_last", got.read_last, want.read_last);
                    if (got.truncated !== want.truncated)
                        report_mismatch("truncated", got.truncated, want.truncated);
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (recover_step(i_in.mode, i_in.label, i_in.payload_byte, i_in.last_byte,
                                 i_in.seq_number, want))
                    result_q.push_back(want);
            end
        end
        o_pending <= result_q.size();
        o_drain_left <= bytes_to_drain();
        o_complete <= complete;
    end
endmodule

// ===== tb/pairwise_xor_packet_recovery_tb.sv =====
// Testbench top: drives packets and reads into the recovery block and gives the verdict.
module pairwise_xor_packet_recovery_tb;
    import pxr_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors, pending, drain_left;
    bit   block_done;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_request = 0;
    int   cycles = 0;

    pxr_in_if  in_ch ();
    pxr_out_if out_ch ();

    pairwise_xor_packet_recovery u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pxr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_drain_left (drain_left),
        .o_complete   (block_done)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    initial begin
        in_ch.valid = 0;
        in_ch.mode = 0;
        in_ch.label = '0;
        in_ch.payload_byte = '0;
        in_ch.last_byte = 0;
        in_ch.seq_number = '0;
        out_ch.ready = 0;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        int hold_left;
        cycles <= cycles + 1;
        // take the request once so the hold-off ends
        if (hold_request > 0 && hold_left == 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_word(logic mode, logic [3:0] lbl, logic [7:0] data, logic last,
                             logic [31:0] seq);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.mode <= mode;
        in_ch.label <= lbl;
        in_ch.payload_byte <= data;
        in_ch.last_byte <= last;
        in_ch.seq_number <= seq;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Later bytes carry a random label, which the block must ignore.
    task automatic send_packet(logic [3:0] lbl, int n, logic [31:0] seq);
        for (int i = 0; i < n; i++)
            push_word(0, (i == 0) ? lbl : 4'($urandom), 8'($urandom), i == n - 1,
                      (i == 0) ? seq : $urandom);
    endtask

    task automatic read_word();
        push_word(1, 4'($urandom), 8'($urandom), 1'($urandom), $urandom);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic drain_block();
        int n;
        wait_drained();
        while (block_done) begin
            n = drain_left;
            if (n == 0) n = 1;
            for (int i = 0; i < n; i++) read_word();
            wait_drained();
        end
    endtask

    function automatic int pick_len();
        return ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 6);
    endfunction

    task automatic run_block(int blk);
        logic [3:0] plan [$];
        logic [3:0] tmp;
        int j, mode;
        for (int k = 1; k <= NUM_PARITY; k++) begin
            mode = $urandom_range(4);
            case (mode)
                0: begin plan.push_back(2*k-1); plan.push_back(2*k); end
                1: begin plan.push_back(2*k-1); plan.push_back(NUM_ORIGINALS + k); end
                2: begin plan.push_back(2*k); plan.push_back(NUM_ORIGINALS + k); end
                3: begin
                    plan.push_back(2*k-1); plan.push_back(2*k);
                    plan.push_back(NUM_ORIGINALS + k);
                end
                default: begin
                    plan.push_back(2*k-1); plan.push_back(2*k-1);
                    plan.push_back(NUM_ORIGINALS + k);
                end
            endcase
        end
        repeat ($urandom_range(0, 2)) plan.push_back(4'($urandom_range(0, 1) ? 0
                                                      : $urandom_range(13, 15)));
        for (int i = plan.size() - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = plan[i];
            plan[i] = plan[j];
            plan[j] = tmp;
        end
        foreach (plan[i]) begin
            // Fill the block and hold off the receiver once in block 3.
            if (blk == 3 && i == 1) hold_request = 400;
            if (blk == 3 && i == 4) hold_request = 0;
            send_packet(plan[i], pick_len(), $urandom);
        end
        // Packets while complete are dropped as busy.
        if ($urandom_range(2) == 0) begin
            wait_drained();
            send_packet(4'($urandom_range(1, NUM_SLOTS)), pick_len(), $urandom);
        end
        drain_block();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: read with no block, uncoded, bad labels, field extremes.
        read_word();
        send_packet(4'd0, 2, 32'hFFFF_FFFF);
        send_packet(4'd13, 1, '0);
        send_packet(4'd15, 1, '0);
        push_word(0, 4'd1, 8'hFF, 0, 32'hFFFF_FFFF);
        push_word(0, 4'd1, 8'h00, 1, '0);
        push_word(0, 4'd9, 8'hA5, 0, '0);
        push_word(0, 4'd9, 8'h5A, 1, '0);
        send_packet(4'd1, 2, 32'h0000_0000);
        send_packet(4'd3, 1, 32'h1234_5678);
        send_packet(4'd10, 1, '0);
        send_packet(4'd6, 1, '0);
        send_packet(4'd11, 2, '0);
        send_packet(4'd7, 1, '0);
        send_packet(4'd8, 1, '0);
        send_packet(4'd12, 1, '0);
        drain_block();

        for (int blk = 0; blk < 4; blk++) begin
            case (blk % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            // Oversize packet, past the buffer size.
            if (blk == 0) send_packet(4'd2, BUFFER_BYTES + 3, $urandom);
            run_block(blk);
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/pxr_pkg.sv
rtl/core/pxr_if.sv
rtl/core/pxr_store.sv
rtl/core/pairwise_xor_packet_recovery.sv
tb/pxr_checker.sv
tb/pairwise_xor_packet_recovery_tb.sv
